// ===== rtl/pcf_pkg.sv =====
// Shared types, register codes and reset values for the point cloud transform filter.
package pcf_pkg;

  localparam int COORD_BITS_DEF     = 18;
  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 64;
  localparam int RANGE_SQ_W         = 36;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATION_QUAT = 3'd0,
    CFG_SHIFT_X       = 3'd1,
    CFG_SHIFT_Y       = 3'd2,
    CFG_HEIGHT_OFFSET = 3'd3,
    CFG_MIN_HEIGHT    = 3'd4,
    CFG_MAX_HEIGHT    = 3'd5,
    CFG_MIN_RANGE_SQ  = 3'd6
  } cfg_idx_e;

  localparam logic [63:0]           RST_ROTATION_QUAT = 64'h4000_0000_0000_0000;
  localparam logic signed [17:0]    RST_MIN_HEIGHT    = 18'sd100;
  localparam logic signed [17:0]    RST_MAX_HEIGHT    = 18'sd2000;
  localparam logic [RANGE_SQ_W-1:0] RST_MIN_RANGE_SQ  = 36'd250000;

  localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN = -24'sh800000;

  typedef struct packed {
    logic [63:0]        rotation_quat;
    logic signed [23:0] shift_x;
    logic signed [23:0] shift_y;
    logic signed [23:0] height_offset;
    logic signed [17:0] min_height;
    logic signed [17:0] max_height;
  } xform_cfg_t;

endpackage

// ===== rtl/pcf_front.sv =====
// Front end: request capture, non-finite drop and minimum range test.
module pcf_front #(
  parameter int CoordBits = 18
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic                                  not_finite_i,
  input  logic signed [CoordBits-1:0]           point_x_i,
  input  logic signed [CoordBits-1:0]           point_y_i,
  input  logic signed [CoordBits-1:0]           point_z_i,
  input  logic [pcf_pkg::RANGE_SQ_W-1:0]        min_range_sq_i,
  output logic                                  push_o,
  output logic [3*CoordBits-1:0]                push_data_o
);
  import pcf_pkg::*;

  localparam int SqW     = 2 * CoordBits;
  localparam int R2Full  = SqW + 2;
  localparam int R2W     = (R2Full > 64) ? 64 : R2Full;
  localparam int CmpW    = (R2W > RANGE_SQ_W) ? R2W : RANGE_SQ_W;

  logic                        v0_q, v1_q;
  logic signed [CoordBits-1:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q;
  logic [SqW-1:0]              sx_q, sy_q, sz_q;
  logic [SqW-1:0]              sx_d, sy_d, sz_d;
  logic [R2Full-1:0]           r2_full;
  logic [CmpW-1:0]             r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= accept_i && !not_finite_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= point_x_i;
    y0_q <= point_y_i;
    z0_q <= point_z_i;
    x1_q <= x0_q;
    y1_q <= y0_q;
    z1_q <= z0_q;
    sx_q <= sx_d;
    sy_q <= sy_d;
    sz_q <= sz_d;
  end

  always_comb begin
    sx_d = SqW'(SqW'(x0_q) * SqW'(x0_q));
    sy_d = SqW'(SqW'(y0_q) * SqW'(y0_q));
    sz_d = SqW'(SqW'(z0_q) * SqW'(z0_q));
  end

  assign r2_full = R2Full'(sx_q) + R2Full'(sy_q) + R2Full'(sz_q);
  assign r2      = CmpW'(r2_full[R2W-1:0]);

  assign push_o      = v1_q && (r2 >= CmpW'(min_range_sq_i));
  assign push_data_o = {x1_q, y1_q, z1_q};

endmodule

// ===== rtl/pcf_queue.sv =====
// Short request queue between the front end and the transform back end.
module pcf_queue #(
  parameter int Width = 54
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  output logic             full_o
);
  import pcf_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [Width-1:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign do_push = push_i && (cnt_q != CntW'(QUEUE_DEPTH));

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));

endmodule

// ===== rtl/pcf_back.sv =====
// Back end: rotation matrix from the quaternion, rotate, height test, translate, saturate.
module pcf_back #(
  parameter int CoordBits    = 18,
  parameter int QuatFracBits = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcf_pkg::xform_cfg_t         cfg_i,
  input  logic                        valid_i,
  input  logic [3*CoordBits-1:0]      data_i,
  output logic                        valid_o,
  output logic signed [23:0]          world_x_o,
  output logic signed [23:0]          world_y_o
);
  import pcf_pkg::*;

  localparam int FB    = 2 * QuatFracBits;
  localparam int EntW  = (FB + 2 > 34) ? FB + 2 : 34;
  localparam int ProdW = EntW + CoordBits;
  localparam int SumW  = ProdW + 2;
  localparam int AccW  = (SumW > 64) ? 64 : SumW;
  localparam int RotW  = AccW - FB;
  localparam int DzW   = ((RotW > 24) ? RotW : 24) + 1;

  localparam logic signed [EntW-1:0] One = EntW'(1) << FB;
  localparam logic signed [SumW-1:0] Rnd = SumW'(1) << (FB - 1);

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  logic signed [EntW-1:0] m_q [3][3];
  logic signed [CoordBits-1:0] p [3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [SumW-1:0]  sum [3];
  logic signed [AccW-1:0]  acc [3];
  logic signed [RotW-1:0]  rot_d [3];
  logic signed [RotW-1:0]  rot_q [3];
  logic                    mv_q, sv_q;
  logic signed [DzW-1:0]   dz, wx, wy;
  logic                    keep;

  function automatic logic signed [23:0] sat24(input logic signed [DzW-1:0] v);
    logic signed [23:0] r;
    if (v > DzW'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (v < DzW'(OUT_MIN)) begin
      r = OUT_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  assign qx = cfg_i.rotation_quat[15:0];
  assign qy = cfg_i.rotation_quat[31:16];
  assign qz = cfg_i.rotation_quat[47:32];
  assign qw = cfg_i.rotation_quat[63:48];

  always_ff @(posedge clk_i) begin
    xx_q <= 32'(qx) * 32'(qx);
    yy_q <= 32'(qy) * 32'(qy);
    zz_q <= 32'(qz) * 32'(qz);
    xy_q <= 32'(qx) * 32'(qy);
    xz_q <= 32'(qx) * 32'(qz);
    yz_q <= 32'(qy) * 32'(qz);
    xw_q <= 32'(qx) * 32'(qw);
    yw_q <= 32'(qy) * 32'(qw);
    zw_q <= 32'(qz) * 32'(qw);
  end

  always_ff @(posedge clk_i) begin
    m_q[0][0] <= One - ((EntW'(yy_q) + EntW'(zz_q)) <<< 1);
    m_q[0][1] <= (EntW'(xy_q) - EntW'(zw_q)) <<< 1;
    m_q[0][2] <= (EntW'(xz_q) + EntW'(yw_q)) <<< 1;
    m_q[1][0] <= (EntW'(xy_q) + EntW'(zw_q)) <<< 1;
    m_q[1][1] <= One - ((EntW'(xx_q) + EntW'(zz_q)) <<< 1);
    m_q[1][2] <= (EntW'(yz_q) - EntW'(xw_q)) <<< 1;
    m_q[2][0] <= (EntW'(xz_q) - EntW'(yw_q)) <<< 1;
    m_q[2][1] <= (EntW'(yz_q) + EntW'(xw_q)) <<< 1;
    m_q[2][2] <= One - ((EntW'(xx_q) + EntW'(yy_q)) <<< 1);
  end

  assign p[0] = data_i[3*CoordBits-1:2*CoordBits];
  assign p[1] = data_i[2*CoordBits-1:CoordBits];
  assign p[2] = data_i[CoordBits-1:0];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= ProdW'(m_q[i][j]) * ProdW'(p[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i]   = SumW'(prod_q[i][0]) + SumW'(prod_q[i][1]) + SumW'(prod_q[i][2]) + Rnd;
      acc[i]   = sum[i][AccW-1:0];
      rot_d[i] = RotW'(acc[i] >>> FB);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      rot_q[i] <= rot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q    <= 1'b0;
      sv_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      mv_q    <= valid_i;
      sv_q    <= mv_q;
      valid_o <= keep;
    end
  end

  always_comb begin
    dz   = DzW'(rot_q[2]) + DzW'(cfg_i.height_offset);
    wx   = DzW'(rot_q[0]) + DzW'(cfg_i.shift_x);
    wy   = DzW'(rot_q[1]) + DzW'(cfg_i.shift_y);
    keep = sv_q && (dz >= DzW'(cfg_i.min_height)) && (dz <= DzW'(cfg_i.max_height));
  end

  always_ff @(posedge clk_i) begin
    world_x_o <= sat24(wx);
    world_y_o <= sat24(wy);
  end

endmodule

// ===== rtl/point_cloud_transform_filter.sv =====
// Top level of the point cloud transform filter with its configuration registers.
// A point is requested by raising start with the point fields; it is taken at a
// rising edge where start is high and busy is low. The front end drops non-finite
// points and points inside the minimum range, and passes the rest through a short
// queue to the back end, which rotates by the configured quaternion, applies the
// height band test and translates x and y with 24-bit saturation.
// A kept point shows its result on world_x_o and world_y_o for exactly one cycle
// with valid_o high; a dropped point produces nothing. A taken point runs through the
// front end, queue and back end registers, and one is taken every cycle busy is low.
// The back end drains the queue every cycle because the receiver cannot stall,
// so busy only rises if the queue fills, which sustained single-cycle draining
// prevents.
// The user writes registers through cfg_we_i, cfg_idx_i and cfg_data_i only while
// the block is idle, which it does not enforce. The rotation matrix follows quaternion
// writes. Reset returns all registers to their defaults and empties the pipeline.
module point_cloud_transform_filter #(
  parameter int COORD_BITS     = pcf_pkg::COORD_BITS_DEF,
  parameter int QUAT_FRAC_BITS = pcf_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_BITS-1:0]     point_x_i,
  input  logic signed [COORD_BITS-1:0]     point_y_i,
  input  logic signed [COORD_BITS-1:0]     point_z_i,
  input  logic                             not_finite_i,
  input  logic                             cfg_we_i,
  input  logic [pcf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pcf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             valid_o,
  output logic signed [23:0]               world_x_o,
  output logic signed [23:0]               world_y_o
);
  import pcf_pkg::*;

  localparam int QW = 3 * COORD_BITS;

  xform_cfg_t            cfg_q;
  logic [RANGE_SQ_W-1:0] min_range_sq_q;
  logic                  accept, push, q_valid, q_full;
  logic [QW-1:0]         push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation_quat <= RST_ROTATION_QUAT;
      cfg_q.shift_x       <= '0;
      cfg_q.shift_y       <= '0;
      cfg_q.height_offset <= '0;
      cfg_q.min_height    <= RST_MIN_HEIGHT;
      cfg_q.max_height    <= RST_MAX_HEIGHT;
      min_range_sq_q      <= RST_MIN_RANGE_SQ;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROTATION_QUAT: cfg_q.rotation_quat <= cfg_data_i;
        CFG_SHIFT_X:       cfg_q.shift_x       <= cfg_data_i[23:0];
        CFG_SHIFT_Y:       cfg_q.shift_y       <= cfg_data_i[23:0];
        CFG_HEIGHT_OFFSET: cfg_q.height_offset <= cfg_data_i[23:0];
        CFG_MIN_HEIGHT:    cfg_q.min_height    <= cfg_data_i[17:0];
        CFG_MAX_HEIGHT:    cfg_q.max_height    <= cfg_data_i[17:0];
        CFG_MIN_RANGE_SQ:  min_range_sq_q      <= cfg_data_i[RANGE_SQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  pcf_front #(
    .CoordBits(COORD_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .not_finite_i,
    .point_x_i,
    .point_y_i,
    .point_z_i,
    .min_range_sq_i(min_range_sq_q),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  pcf_queue #(
    .Width(QW)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (q_valid),
    .valid_o    (q_valid),
    .data_o     (q_data),
    .full_o     (q_full)
  );

  pcf_back #(
    .CoordBits   (COORD_BITS),
    .QuatFracBits(QUAT_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg_q),
    .valid_i  (q_valid),
    .data_i   (q_data),
    .valid_o,
    .world_x_o,
    .world_y_o
  );

endmodule

// ===== verif/point_cloud_transform_filter_tb.sv =====
// Self-checking testbench for the point cloud transform filter with a queued driver and a monitor.
module point_cloud_transform_filter_tb;
  import pcf_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int FB            = 2 * QUAT_FRAC_BITS_DEF;

  typedef enum logic [1:0] {STEP_POINT, STEP_WRITE, STEP_SETTLE} step_kind_e;

  typedef struct {
    step_kind_e         kind;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic               nf;
    int unsigned        gap;
    cfg_idx_e           idx;
    logic [63:0]        data;
  } step_t;

  typedef struct packed {
    logic signed [23:0] wx;
    logic signed [23:0] wy;
  } world_pt_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic signed [17:0]    point_x_i;
  logic signed [17:0]    point_y_i;
  logic signed [17:0]    point_z_i;
  logic                  not_finite_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  valid_o;
  logic signed [23:0]    world_x_o;
  logic signed [23:0]    world_y_o;

  step_t                 plan[$];
  world_pt_t             pending_world[$];
  xform_cfg_t            cur_cfg;
  logic [RANGE_SQ_W-1:0] cur_range;
  int unsigned           issued_cnt;
  int unsigned           taken_cnt;
  int unsigned           quiet_cycles;
  int unsigned           gap_left;
  int unsigned           cycle_cnt;
  bit                    gaps_on;
  bit                    failed;

  point_cloud_transform_filter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .not_finite_i (not_finite_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .valid_o      (valid_o),
    .world_x_o    (world_x_o),
    .world_y_o    (world_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [23:0] sat24(input longint v);
    if (v > longint'(OUT_MAX)) return OUT_MAX;
    if (v < longint'(OUT_MIN)) return OUT_MIN;
    return 24'(v);
  endfunction

  function automatic bit predict_world(input logic signed [17:0] px, py, pz, input logic nf,
                                       output world_pt_t res);
    longint x, y, z, qx, qy, qz, qw, one, half, rx, ry, rz, dz;
    longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
    x = px;
    y = py;
    z = pz;
    res = '0;
    if (nf) return 1'b0;
    if (x * x + y * y + z * z < longint'(cur_range)) return 1'b0;
    qx = longint'($signed(cur_cfg.rotation_quat[15:0]));
    qy = longint'($signed(cur_cfg.rotation_quat[31:16]));
    qz = longint'($signed(cur_cfg.rotation_quat[47:32]));
    qw = longint'($signed(cur_cfg.rotation_quat[63:48]));
    one = longint'(1) <<< FB;
    half = one >>> 1;
    xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; xz = qx * qz; yz = qy * qz;
    xw = qx * qw; yw = qy * qw; zw = qz * qw;
    rx = ((one - 2 * (yy + zz)) * x + 2 * (xy - zw) * y + 2 * (xz + yw) * z + half) >>> FB;
    ry = (2 * (xy + zw) * x + (one - 2 * (xx + zz)) * y + 2 * (yz - xw) * z + half) >>> FB;
    rz = (2 * (xz - yw) * x + 2 * (yz + xw) * y + (one - 2 * (xx + yy)) * z + half) >>> FB;
    dz = rz + longint'(cur_cfg.height_offset);
    if (dz < longint'(cur_cfg.min_height) || dz > longint'(cur_cfg.max_height)) return 1'b0;
    res.wx = sat24(rx + longint'(cur_cfg.shift_x));
    res.wy = sat24(ry + longint'(cur_cfg.shift_y));
    return 1'b1;
  endfunction

  function automatic logic signed [17:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 18'h1FFFF;
      1: return 18'h20000;
      2, 3, 4: return 18'($urandom);
      default: return 18'(int'($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  task automatic add_point(input logic signed [17:0] x, y, z, input logic nf);
    step_t s;
    s.kind = STEP_POINT;
    s.x = x;
    s.y = y;
    s.z = z;
    s.nf = nf;
    s.gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    plan.push_back(s);
  endtask

  task automatic add_write(input cfg_idx_e idx, input logic [63:0] data);
    step_t s;
    s.kind = STEP_WRITE;
    s.idx = idx;
    s.data = data;
    plan.push_back(s);
  endtask

  task automatic add_settle();
    step_t s;
    s.kind = STEP_SETTLE;
    plan.push_back(s);
  endtask

  task automatic program_filter(input logic [63:0] quat, input logic signed [23:0] sx, sy, hoff,
                                input logic signed [17:0] hmin, hmax,
                                input logic [RANGE_SQ_W-1:0] rmin);
    add_settle();
    add_write(CFG_ROTATION_QUAT, quat);
    add_write(CFG_SHIFT_X, {40'b0, sx});
    add_write(CFG_SHIFT_Y, {40'b0, sy});
    add_write(CFG_HEIGHT_OFFSET, {40'b0, hoff});
    add_write(CFG_MIN_HEIGHT, {46'b0, hmin});
    add_write(CFG_MAX_HEIGHT, {46'b0, hmax});
    add_write(CFG_MIN_RANGE_SQ, {28'b0, rmin});
    add_settle();
  endtask

  always @(negedge clk_i) begin : driver
    logic nxt_start;
    logic nxt_we;
    nxt_start = 1'b0;
    nxt_we = 1'b0;
    if (rst_ni) begin
      if (start && taken_cnt != issued_cnt) begin
        nxt_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (plan.size() > 0) begin
        case (plan[0].kind)
          STEP_POINT: begin
            point_x_i <= plan[0].x;
            point_y_i <= plan[0].y;
            point_z_i <= plan[0].z;
            not_finite_i <= plan[0].nf;
            gap_left = plan[0].gap;
            issued_cnt++;
            nxt_start = 1'b1;
            void'(plan.pop_front());
          end
          STEP_WRITE: begin
            cfg_idx_i <= plan[0].idx;
            cfg_data_i <= plan[0].data;
            nxt_we = 1'b1;
            void'(plan.pop_front());
          end
          default: begin
            if (pending_world.size() != 0) begin
              quiet_cycles = 0;
            end else if (quiet_cycles >= SETTLE_CYCLES) begin
              quiet_cycles = 0;
              void'(plan.pop_front());
            end else begin
              quiet_cycles++;
            end
          end
        endcase
      end
    end
    start <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  always @(posedge clk_i) begin : monitor
    world_pt_t want;
    world_pt_t got;
    if (rst_ni) begin
      cycle_cnt++;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROTATION_QUAT: cur_cfg.rotation_quat = cfg_data_i;
          CFG_SHIFT_X:       cur_cfg.shift_x = cfg_data_i[23:0];
          CFG_SHIFT_Y:       cur_cfg.shift_y = cfg_data_i[23:0];
          CFG_HEIGHT_OFFSET: cur_cfg.height_offset = cfg_data_i[23:0];
          CFG_MIN_HEIGHT:    cur_cfg.min_height = cfg_data_i[17:0];
          CFG_MAX_HEIGHT:    cur_cfg.max_height = cfg_data_i[17:0];
          CFG_MIN_RANGE_SQ:  cur_range = cfg_data_i[RANGE_SQ_W-1:0];
          default: ;
        endcase
      end
      if (valid_o) begin
        got = {world_x_o, world_y_o};
        if (pending_world.size() == 0) begin
          $display("%0t: unexpected result expected none got (%0d, %0d)", $time, got.wx, got.wy);
          failed = 1'b1;
        end else begin
          want = pending_world.pop_front();
          if (got.wx !== want.wx) begin
            $display("%0t: world_x expected %0d got %0d", $time, want.wx, got.wx);
            failed = 1'b1;
          end
          if (got.wy !== want.wy) begin
            $display("%0t: world_y expected %0d got %0d", $time, want.wy, got.wy);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        taken_cnt++;
        if (predict_world(point_x_i, point_y_i, point_z_i, not_finite_i, want)) begin
          pending_world.push_back(want);
        end
      end
      if (cycle_cnt > LIMIT_CYCLES) begin
        $display("%0t: timeout with %0d results outstanding", $time, pending_world.size());
        $display("point_cloud_transform_filter test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0]           quat;
    logic signed [23:0]    sx;
    logic signed [23:0]    sy;
    logic signed [23:0]    hoff;
    logic signed [17:0]    hmin;
    logic signed [17:0]    hmax;
    logic [RANGE_SQ_W-1:0] rmin;
    rst_ni = 1'b0;
    start = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    not_finite_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cur_cfg = '0;
    cur_cfg.rotation_quat = RST_ROTATION_QUAT;
    cur_cfg.min_height = RST_MIN_HEIGHT;
    cur_cfg.max_height = RST_MAX_HEIGHT;
    cur_range = RST_MIN_RANGE_SQ;
    issued_cnt = 0;
    taken_cnt = 0;
    quiet_cycles = 0;
    gap_left = 0;
    cycle_cnt = 0;
    failed = 1'b0;
    gaps_on = 1'b1;

    // Reset defaults: identity rotation, range and height band boundaries.
    add_point(0, 0, 0, 0);
    add_point(0, 0, 500, 0);
    add_point(0, 0, 499, 0);
    add_point(300, 400, 100, 0);
    add_point(300, 400, 99, 0);
    add_point(0, 0, 2000, 0);
    add_point(0, 0, 2001, 0);
    add_point(0, 0, 1000, 1);
    add_point(18'h1FFFF, 18'h20000, 1000, 0);
    add_point(18'h20000, 18'h1FFFF, 2000, 0);
    add_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 0);

    // Quarter turn about z with extreme shifts, so outputs saturate both ways.
    program_filter({16'd11585, 16'd11585, 32'h0}, OUT_MAX, OUT_MIN, 24'sd0,
                   18'h20000, 18'h1FFFF, 36'd0);
    add_point(18'h1FFFF, 18'h20000, 0, 0);
    add_point(18'h20000, 18'h1FFFF, 18'h20000, 0);
    add_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 0);
    add_point(0, 0, 0, 0);
    add_point(-1, -1, -1, 0);
    add_point(4000, -3000, 1234, 1);

    // Half turn about x with an inverted height band.
    program_filter({48'h0, 16'h4000}, 24'sd0, 24'sd0, 24'sd0, 18'sd10, -18'sd10, 36'd0);
    add_point(100, 100, 0, 0);
    add_point(1000, 1000, 1000, 0);
    add_point(5, 5, 5, 0);

    // Largest range floor with a non-unit quaternion and extreme offsets.
    program_filter(64'hFFFF_FFFF_FFFF_FFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                   18'h20000, 18'h1FFFF, 36'hF_FFFF_FFFF);
    add_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 0);
    add_point(18'h20000, 18'h20000, 18'h20000, 0);

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 7))
        0: quat = {16'h4000, 48'h0};
        1: quat = {16'd11585, 16'd11585, 32'h0};
        2: quat = {48'h0, 16'h4000};
        3: quat = {16'd11585, 32'h0, 16'd11585};
        4: quat = {4{16'h2000}};
        5: quat = {16'd11585, 16'h0, 16'hD2BF, 16'h0};
        default: quat = {$urandom, $urandom};
      endcase
      sx = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                        : 24'(int'($urandom_range(0, 200000)) - 100000);
      sy = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                        : 24'(int'($urandom_range(0, 200000)) - 100000);
      hoff = 24'(int'($urandom_range(0, 4000)) - 2000);
      if ($urandom_range(0, 7) == 0) begin
        hmin = 18'h20000;
        hmax = 18'h1FFFF;
      end else begin
        hmin = 18'(int'($urandom_range(0, 4000)) - 3000);
        hmax = 18'(int'(hmin) + int'($urandom_range(0, 5000)));
      end
      rmin = ($urandom_range(0, 7) == 0) ? 36'd0 : 36'($urandom_range(0, 4000000));
      program_filter(quat, sx, sy, hoff, hmin, hmax, rmin);
      gaps_on = (ph != 7);
      for (int n = 0; n < 250; n++) begin
        add_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 15) == 0);
        if (gaps_on && $urandom_range(0, 99) == 0) add_settle();
      end
    end
    add_settle();

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (plan.size() != 0) @(posedge clk_i);
    if (!failed && pending_world.size() == 0) begin
      $display("point_cloud_transform_filter test passed");
    end else begin
      $display("point_cloud_transform_filter test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pcf_pkg.sv
rtl/pcf_front.sv
rtl/pcf_queue.sv
rtl/pcf_back.sv
rtl/point_cloud_transform_filter.sv
verif/point_cloud_transform_filter_tb.sv
